// ----- rtl/bum_pkg.sv -----
// Package for the block usage map allocator: sizes, codes, shared types.
// No dependencies; imported by every module of the block.
package bum_pkg;

    localparam int BLOCKS   = 1024;               // marks in the map
    localparam int WORD_W   = 32;                 // marks per memory word
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WORDS    = BLOCKS / WORD_W;
    localparam int WA_W     = $clog2(WORDS);
    localparam int BLK_W    = WA_W + BIT_W;       // full block index
    localparam int CNT_W    = $clog2(BLOCKS + 1); // counts 0..BLOCKS
    localparam int GRP_W    = 8;                  // encoder group width
    localparam int GROUPS   = WORD_W / GRP_W;
    localparam int GSEL_W   = $clog2(GROUPS);
    localparam int GBIT_W   = $clog2(GRP_W);

    localparam int ACTION_W = 2;
    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int CIDX_W   = 1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FORMAT = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_MARK   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    localparam logic [CIDX_W-1:0] REG_RESERVED_LOW  = 1'b0;
    localparam logic [CIDX_W-1:0] REG_RESERVED_HIGH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FORMAT,
        S_SCAN,
        S_RMW_RD,
        S_RMW_WR
    } t_state;

    typedef struct packed {
        logic              we;
        logic [WA_W-1:0]   waddr;
        logic [WORD_W-1:0] wdata;
        logic [WA_W-1:0]   raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic [BLOCK_W-1:0] granted;
        t_status            status;
    } t_result;

endpackage

// ----- rtl/bum_map_mem.sv -----
// Usage map storage: WORDS x WORD_W marks, one write and one read port,
// registered read data. Depends on bum_pkg.
module bum_map_mem
    import bum_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bum_ctrl.sv -----
// Sequencer of the allocator: clearing and format sweeps, first-fit scan,
// read-modify-write of single marks. Depends on bum_pkg.
module bum_ctrl
    import bum_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_action           i_action,
    input  logic [BLOCK_W-1:0] i_block,
    input  logic [CFG_W-1:0]  i_res_low,
    input  logic [CFG_W-1:0]  i_res_high,
    input  logic [WORD_W-1:0] i_rdata,
    output t_mem_req          o_req,
    output t_result           o_res,
    output logic              o_busy
);

    t_state             r_state, n_state;
    logic [WA_W-1:0]    r_ptr, n_ptr;
    logic               r_chk, n_chk;
    logic [WA_W-1:0]    r_chk_addr, n_chk_addr;
    t_action            r_action;
    logic [BLOCK_W-1:0] r_block;

    logic               ptr_last;
    logic               chk_last;
    logic [CNT_W-1:0]   lo_cnt, hi_cnt, hi_thr, base, lo_n, hi_n;
    logic [WORD_W-1:0]  lo_mask, hi_mask, zeros;
    logic               found;
    logic [GROUPS-1:0]  grp_hit;
    logic [GSEL_W-1:0]  grp_sel;
    logic [GRP_W-1:0]   grp_bits;
    logic [GBIT_W-1:0]  grp_bit;
    logic [BIT_W-1:0]   free_bit;
    logic [BLK_W-1:0]   blk_idx;
    logic               in_range;

    assign ptr_last = (r_ptr == WA_W'(WORDS - 1));
    assign chk_last = (r_chk_addr == WA_W'(WORDS - 1));
    assign blk_idx  = BLK_W'(r_block);
    assign in_range = (32'(r_block) < 32'(BLOCKS));

    // reserve counts, saturated to the map size
    assign lo_cnt = (32'(i_res_low) > 32'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(i_res_low);
    assign hi_cnt = (32'(i_res_high) > 32'(BLOCKS)) ? CNT_W'(BLOCKS) : CNT_W'(i_res_high);
    assign hi_thr = CNT_W'(BLOCKS) - hi_cnt;
    assign base   = CNT_W'({r_ptr, BIT_W'(0)});
    assign lo_n   = (lo_cnt > base) ? (lo_cnt - base) : '0;
    assign hi_n   = (hi_thr > base) ? (hi_thr - base) : '0;

    always_comb begin
        if (lo_n >= CNT_W'(WORD_W)) begin
            lo_mask = '1;
        end else begin
            lo_mask = ~({WORD_W{1'b1}} << lo_n[BIT_W-1:0]);
        end
        if (hi_n >= CNT_W'(WORD_W)) begin
            hi_mask = '0;
        end else begin
            hi_mask = {WORD_W{1'b1}} << hi_n[BIT_W-1:0];
        end
    end

    // lowest free mark: pick group, then bit within group
    assign zeros = ~i_rdata;
    assign found = |zeros;

    always_comb begin
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            grp_hit[g] = |zeros[g*GRP_W +: GRP_W];
            if (grp_hit[g]) begin
                grp_sel = GSEL_W'(g);
            end
        end
        grp_bits = zeros[grp_sel*GRP_W +: GRP_W];
        grp_bit  = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                grp_bit = GBIT_W'(b);
            end
        end
        free_bit = {grp_sel, grp_bit};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (ptr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_FORMAT: n_state = S_FORMAT;
                        ACT_ALLOC:  n_state = S_SCAN;
                        default:    n_state = S_RMW_RD;
                    endcase
                end
            end
            S_FORMAT: begin
                if (ptr_last) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_chk && (found || chk_last)) n_state = S_IDLE;
            end
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_ptr         = r_ptr;
        n_chk         = 1'b0;
        n_chk_addr    = r_chk_addr;
        o_req.we      = 1'b0;
        o_req.waddr   = r_ptr;
        o_req.wdata   = lo_mask | hi_mask;
        o_req.raddr   = r_ptr;
        o_res.valid   = 1'b0;
        o_res.granted = r_block;
        o_res.status  = STAT_OK;
        unique case (r_state)
            S_CLEAR: begin
                o_req.we    = 1'b1;
                o_req.wdata = '0;
                n_ptr       = r_ptr + 1'b1;
            end
            S_IDLE: begin
                n_ptr = '0;
            end
            S_FORMAT: begin
                o_req.we    = 1'b1;
                n_ptr       = r_ptr + 1'b1;
                o_res.valid = ptr_last;
            end
            S_SCAN: begin
                // reads run one word ahead of the check
                n_ptr      = r_ptr + 1'b1;
                n_chk      = 1'b1;
                n_chk_addr = r_ptr;
                if (r_chk) begin
                    if (found) begin
                        o_req.we      = 1'b1;
                        o_req.waddr   = r_chk_addr;
                        o_req.wdata   = i_rdata | (WORD_W'(1) << free_bit);
                        o_res.valid   = 1'b1;
                        o_res.granted = BLOCK_W'({r_chk_addr, free_bit});
                    end else if (chk_last) begin
                        o_res.valid  = 1'b1;
                        o_res.status = STAT_FULL;
                    end
                end
            end
            S_RMW_RD: begin
                o_req.raddr = blk_idx[BLK_W-1:BIT_W];
            end
            S_RMW_WR: begin
                o_res.valid = 1'b1;
                o_req.waddr = blk_idx[BLK_W-1:BIT_W];
                if (!in_range) begin
                    o_res.status = STAT_RANGE;
                end else begin
                    o_req.we = 1'b1;
                    if (r_action == ACT_MARK) begin
                        o_req.wdata = i_rdata | (WORD_W'(1) << blk_idx[BIT_W-1:0]);
                    end else begin
                        o_req.wdata = i_rdata & ~(WORD_W'(1) << blk_idx[BIT_W-1:0]);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        if (r_state == S_IDLE && i_start) begin
            r_action <= i_action;
            r_block  <= i_block;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/block_usage_map_allocator.sv -----
// Block usage map allocator: first-fit free-block bitmap held in one RAM.
// One item at a time; busy stays high until its strobe, a scan covers one 32-mark word/cycle.
// Reset: clearing pass over every word (busy high); registers return to 30 and 2.
// Results carry a one-cycle strobe; the receiver cannot stall.
// Depends on bum_pkg, bum_map_mem, bum_ctrl.
module block_usage_map_allocator
    import bum_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BLOCK_W-1:0]  i_block,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // result side
    output logic                o_valid,
    output logic [BLOCK_W-1:0]  o_granted_block,
    output logic [STATUS_W-1:0] o_status
);

    logic [CFG_W-1:0]   r_res_low;
    logic [CFG_W-1:0]   r_res_high;
    logic               r_valid;
    logic [BLOCK_W-1:0] r_granted;
    t_status            r_status;

    t_mem_req           mem_req;
    logic [WORD_W-1:0]  mem_rdata;
    t_result            res;
    logic               ctrl_busy;

    // Reserve counts; to be written only while the block is idle (the user's duty; the block does not enforce it).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_low  <= CFG_W'(30);
            r_res_high <= CFG_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESERVED_LOW:  r_res_low  <= i_cfg_data;
                REG_RESERVED_HIGH: r_res_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bum_map_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bum_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_action   (t_action'(i_action)),
        .i_block    (i_block),
        .i_res_low  (r_res_low),
        .i_res_high (r_res_high),
        .i_rdata    (mem_rdata),
        .o_req      (mem_req),
        .o_res      (res),
        .o_busy     (ctrl_busy)
    );

    // Result beat register: strobe is reset, payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_granted <= res.granted;
            r_status  <= res.status;
        end
    end

    assign busy            = ctrl_busy;
    assign o_valid         = r_valid;
    assign o_granted_block = r_granted;
    assign o_status        = r_status;

endmodule

// ----- rtl/bum_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
// Depends on bum_pkg and block_usage_map_allocator.
module bum_checker
    import bum_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_valid,
    input logic [STATUS_W-1:0] o_status
);

    // reset starts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_valid)
        else $error("no clearing pass after reset");

    // an accepted command holds the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("command accepted without going busy");

    // a result beat closes the command
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while still busy");

    // one beat per command
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result beats");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STAT_OK || o_status == STAT_FULL
                     || o_status == STAT_RANGE))
        else $error("unknown status code");

endmodule

bind block_usage_map_allocator bum_checker u_bum_checker (.*);

// ----- tb/block_usage_map_allocator_tb.sv -----
// Testbench for block_usage_map_allocator: drives command beats, predicts every result
// from its own copy of the usage map and registers, and checks the strobed results.
// Depends on bum_pkg and the allocator RTL.
module block_usage_map_allocator_tb
    import bum_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one command beat as queued for the driver
    typedef struct {
        t_action                act;
        logic [BLOCK_W-1:0]     blk;
    } t_cmd;

    // one result as the block should present it
    typedef struct {
        logic [BLOCK_W-1:0]     granted;
        t_status                status;
    } t_grant;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ACTION_W-1:0]    i_action = ACT_FORMAT;
    logic [BLOCK_W-1:0]     i_block = '0;
    logic                   i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]      i_cfg_idx = REG_RESERVED_LOW;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   o_valid;
    logic [BLOCK_W-1:0]     o_granted_block;
    logic [STATUS_W-1:0]    o_status;

    block_usage_map_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_block         (i_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_granted_block (o_granted_block),
        .o_status        (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow state: usage marks (1 = used) and the two reserve counts.
    // Reset values mirror the block: map all free, counts 30 and 2.
    // ------------------------------------------------------------------
    bit [BLOCKS-1:0]        shadow_map = '0;
    logic [CFG_W-1:0]       low_reserve = 11'd30;
    logic [CFG_W-1:0]       high_reserve = 11'd2;

    t_cmd                   pending_cmds[$];
    t_grant                 expected_grants[$];
    int                     error_count = 0;
    int                     gap_mode = 0;   // 0: back-to-back beats, 1: random gaps
    int                     gap_left = 0;

    // Applies one command to the shadow map and returns the result it must produce.
    function automatic t_grant apply_map_action(t_action act, logic [BLOCK_W-1:0] blk);
        t_grant g;
        int     lo;
        int     hi;
        bit     found;
        g.granted = blk;
        g.status  = STAT_OK;
        found     = 1'b0;
        case (act)
            ACT_FORMAT: begin
                // counts above the map size saturate; overlapping ranges just stay used
                lo = (int'(low_reserve) > BLOCKS) ? BLOCKS : int'(low_reserve);
                hi = (int'(high_reserve) > BLOCKS) ? BLOCKS : int'(high_reserve);
                shadow_map = '0;
                for (int i = 0; i < lo; i++) shadow_map[i] = 1'b1;
                for (int i = 0; i < hi; i++) shadow_map[BLOCKS-1-i] = 1'b1;
            end
            ACT_ALLOC: begin
                // first fit: lowest free mark wins
                for (int i = 0; i < BLOCKS && !found; i++) begin
                    if (!shadow_map[i]) begin
                        shadow_map[i] = 1'b1;
                        g.granted     = BLOCK_W'(i);
                        found         = 1'b1;
                    end
                end
                if (!found) g.status = STAT_FULL;
            end
            default: begin
                if (int'(blk) >= BLOCKS) g.status = STAT_RANGE;
                else shadow_map[blk] = (act == ACT_MARK);
            end
        endcase
        return g;
    endfunction

    // Idle length after a beat: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (gap_mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Block index near a boundary of interest, kept inside the map.
    function automatic logic [BLOCK_W-1:0] near_block(int center);
        int b;
        b = center + int'($urandom_range(0, 32)) - 16;
        if (b < 0) b = 0;
        if (b > BLOCKS - 1) b = BLOCKS - 1;
        return BLOCK_W'(b);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents the next queued command and holds it until the
    // beat is taken (start high, busy low). The expectation is computed
    // at the accepting edge, so the shadow map follows the block's order.
    // start gets at most one nonblocking write per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_p
        int   nxt_gap;
        t_cmd c;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (start) begin
                expected_grants.push_back(apply_map_action(t_action'(i_action), i_block));
                nxt_gap = pick_gap();
            end else begin
                nxt_gap = gap_left;
            end
            if (nxt_gap == 0 && pending_cmds.size() != 0) begin
                c = pending_cmds.pop_front();
                start    <= 1'b1;
                i_action <= c.act;
                i_block  <= c.blk;
                gap_left <= 0;
            end else begin
                start <= 1'b0;
                if (nxt_gap != 0) gap_left <= nxt_gap - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe is matched against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_p
        t_grant e;
        if (i_rst_n && o_valid) begin
            if (expected_grants.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: granted=%0d status=%0d",
                             o_granted_block, o_status);
                error_count++;
            end else begin
                e = expected_grants.pop_front();
                if (o_granted_block !== e.granted || o_status !== e.status) begin
                    if (error_count < 10)
                        $display("mismatch: granted exp %0d got %0d, status exp %0d got %0d",
                                 e.granted, o_granted_block, e.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Waits until no beat is queued or in flight and the block reports idle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_grants.size() != 0 || busy);
    endtask

    // Register write; only called while idle, so the shadow copy updates at once.
    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_RESERVED_LOW) low_reserve = val;
        else high_reserve = val;
    endtask

    task automatic queue_cmd(t_action act, logic [BLOCK_W-1:0] blk);
        t_cmd c;
        c.act = act;
        c.blk = blk;
        pending_cmds.push_back(c);
    endtask

    // Reserve settings for the random phases: extremes, overlap, near-full maps,
    // both word-boundary counts, and two picked at random.
    int phase_low[8]  = '{30, 0, 1000, 600, 512, 1020, 2047, 5};
    int phase_high[8] = '{2, 0, 20, 600, 511, 3, 0, 1019};

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stim_p
        int r;
        int lo_edge;
        int hi_edge;
        t_action act;
        logic [BLOCK_W-1:0] blk;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait_idle();   // covers the clearing pass after reset

        // directed: reset counts (30 low, 2 high), first fit and re-use of freed blocks
        queue_cmd(ACT_FORMAT, 10'd1023);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_FREE,   10'd30);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_MARK,   10'd32);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_FREE,   10'd0);
        queue_cmd(ACT_ALLOC,  10'd0);
        wait_idle();

        // whole map reserved low: full map, then holes at the 511/512 boundary
        write_reg(REG_RESERVED_LOW, 11'd1024);
        write_reg(REG_RESERVED_HIGH, 11'd0);
        queue_cmd(ACT_FORMAT, 10'd0);
        queue_cmd(ACT_ALLOC,  10'h155);
        queue_cmd(ACT_FREE,   10'd511);
        queue_cmd(ACT_FREE,   10'd512);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_ALLOC,  10'd0);
        queue_cmd(ACT_ALLOC,  10'h3FF);
        wait_idle();

        // both counts saturate and overlap; repeated free/mark of the same block
        write_reg(REG_RESERVED_LOW, 11'd2047);
        write_reg(REG_RESERVED_HIGH, 11'd2047);
        queue_cmd(ACT_FORMAT, 10'h2AA);
        queue_cmd(ACT_ALLOC,  10'h155);
        queue_cmd(ACT_FREE,   10'd1023);
        queue_cmd(ACT_MARK,   10'd1023);
        queue_cmd(ACT_MARK,   10'd1023);
        queue_cmd(ACT_FREE,   10'd0);
        queue_cmd(ACT_FREE,   10'd0);
        queue_cmd(ACT_ALLOC,  10'd0);
        wait_idle();

        // random phases: each starts from a format under its own reserve counts
        phase_low[6]  = $urandom_range(0, 2047);
        phase_high[6] = $urandom_range(0, 2047);
        phase_low[7]  = $urandom_range(0, 1024);
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_RESERVED_LOW, CFG_W'(phase_low[p]));
            write_reg(REG_RESERVED_HIGH, CFG_W'(phase_high[p]));
            gap_mode = (p % 3 == 2) ? 0 : 1;
            lo_edge  = (phase_low[p] > BLOCKS) ? BLOCKS : phase_low[p];
            hi_edge  = BLOCKS - 1 - ((phase_high[p] > BLOCKS) ? BLOCKS : phase_high[p]);
            queue_cmd(ACT_FORMAT, BLOCK_W'($urandom_range(0, BLOCKS - 1)));
            for (int n = 0; n < 190; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4)       act = ACT_FORMAT;
                else if (r < 50) act = ACT_ALLOC;
                else if (r < 78) act = ACT_FREE;
                else             act = ACT_MARK;
                // frees and marks cluster at the reserve edges, where allocation works
                r = $urandom_range(0, 9);
                if (r < 4)      blk = BLOCK_W'($urandom_range(0, BLOCKS - 1));
                else if (r < 7) blk = near_block(lo_edge);
                else            blk = near_block(hi_edge);
                queue_cmd(act, blk);
            end
            wait_idle();
        end

        // drain: leave room for any stray strobe after the last result
        repeat (40) @(posedge i_clk);
        error_count += expected_grants.size();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog_p
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
